@@ rtl/min_heap_priority_queue_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the priority queue top level
// Implication checks sampled on the rising clock edge, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define MHPQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mhpq_pkg.sv @@
// ---------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the priority queue cells and top level.
// ---------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned KEY_W = 32;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } mhpq_status_e;

  typedef struct packed {
    logic             ins;
    logic             ext;
    logic [KEY_W-1:0] key;
  } mhpq_op_t;

  typedef struct packed {
    logic valid;
    logic tail;
  } mhpq_pos_t;

endpackage

@@ rtl/mhpq_if.sv @@
// ---------------------------------------------------------------------------
// mhpq_req_if / mhpq_rsp_if
// Valid/ready channels carrying request and response beats.
// ---------------------------------------------------------------------------
interface mhpq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic signed [31:0]          key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface mhpq_rsp_if #(
  parameter int unsigned CNT_W = 7
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic signed [31:0]          out_key;
  logic [CNT_W-1:0]            count;

  modport source (output valid, status, out_key, count, input ready);
  modport sink   (input valid, status, out_key, count, output ready);
endinterface

@@ rtl/mhpq_cell.sv @@
// ---------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted key chain; shifts towards the tail on insert and
// towards the head on extract.
// ---------------------------------------------------------------------------
module mhpq_cell (
  input  logic                      clk_i,
  input  mhpq_pkg::mhpq_op_t        op_i,
  input  mhpq_pkg::mhpq_pos_t       pos_i,
  input  logic                      prev_gt_i,
  input  logic [mhpq_pkg::KEY_W-1:0] prev_val_i,
  input  logic [mhpq_pkg::KEY_W-1:0] next_val_i,
  output logic                      gt_o,
  output logic [mhpq_pkg::KEY_W-1:0] val_o
);
  import mhpq_pkg::*;

  logic [KEY_W-1:0] val_q;
  logic [KEY_W-1:0] val_d;
  logic             gt;

  assign gt = pos_i.valid && ($signed(val_q) > $signed(op_i.key));

  always_comb begin
    val_d = val_q;
    if (op_i.ins) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt || pos_i.tail) begin
        val_d = op_i.key;
      end
    end else if (op_i.ext) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign gt_o  = gt;
  assign val_o = val_q;

endmodule

@@ rtl/min_heap_priority_queue_top.sv @@
// ---------------------------------------------------------------------------
// min_heap_priority_queue_top
// Priority queue of signed keys held as a sorted chain of cells.
// ---------------------------------------------------------------------------
//  channel  dir  fields                   role
//  req_i    in   func, key                insert a key or extract the minimum
//  rsp_o    out  status, out_key, count   one beat per request beat
//
// Every cell compares a request key with its own entry at once, so a beat can
// be taken in every cycle while the response register is not stalled.
// The response sits in an output register; a new request is taken while that
// register is empty or being emptied in the same cycle.
// Reset clears the entry count and the output valid flag; cell contents
// are not cleared and are only read below the count.
// ---------------------------------------------------------------------------
module min_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_req_if.sink   req_i,
  mhpq_rsp_if.source rsp_o
);
  import mhpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q;
  mhpq_status_e     status_q, status_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic [CNT_W-1:0] ocnt_q;

  logic             fire;
  logic             is_full;
  logic             is_empty;
  mhpq_op_t         op;

  logic [KEY_W-1:0] cell_val [CAPACITY];
  logic             cell_gt  [CAPACITY];

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign is_full     = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty    = (cnt_q == '0);

  assign op.ins = fire && (req_i.func == FUNC_INSERT) && !is_full;
  assign op.ext = fire && (req_i.func == FUNC_EXTRACT) && !is_empty;
  assign op.key = req_i.key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mhpq_pos_t        pos;
    logic             prev_gt;
    logic [KEY_W-1:0] prev_val;
    logic [KEY_W-1:0] next_val;

    assign pos.valid = (CNT_W'(i) < cnt_q);
    assign pos.tail  = (CNT_W'(i) == cnt_q);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = op.key;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    mhpq_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .pos_i      (pos),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .gt_o       (cell_gt[i]),
      .val_o      (cell_val[i])
    );
  end

  always_comb begin
    cnt_d    = cnt_q;
    status_d = ST_INSERTED;
    okey_d   = '0;
    if (req_i.func == FUNC_INSERT) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        cnt_d    = cnt_q + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
        okey_d   = '1;
      end else begin
        status_d = ST_EXTRACTED;
        okey_d   = cell_val[0];
        cnt_d    = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      ocnt_q   <= cnt_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.out_key = okey_q;
  assign rsp_o.count   = ocnt_q;

`include "min_heap_priority_queue_top_assert.svh"

  `MHPQ_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(CAPACITY),
                   "Entry count exceeds capacity.")
  `MHPQ_ASSERT_NEXT(a_ins_count, clk_i, rst_ni, op.ins,
                    cnt_q == $past(cnt_q) + CNT_W'(1),
                    "Accepted insert did not raise the entry count.")
  `MHPQ_ASSERT_NEXT(a_ext_order, clk_i, rst_ni, op.ext,
                    (cnt_q == '0) || ($signed(cell_val[0]) >= $signed(okey_q)),
                    "New head is smaller than the key just extracted.")

endmodule

@@ test/tb_min_heap_priority_queue_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_min_heap_priority_queue_top
// Self-checking bench for the priority queue. Request beats are sent with
// random gaps and the response side stalls at random. A heap kept in the
// bench predicts every response. Each response beat is compared in order
// with the oldest prediction. The bench covers the empty and full cases,
// equal and extreme keys, random mixes, and a long response stall.
// ---------------------------------------------------------------------------
module tb_min_heap_priority_queue_top;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH   = 64;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    mhpq_status_e       status;
    logic signed [31:0] out_key;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic clk;
  logic rst_n;

  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_idle_en     = 1'b1;
  bit          rx_idle_en     = 1'b1;

  logic signed [31:0] model_keys [HEAP_DEPTH];
  int unsigned        model_size = 0;
  queue_result_t      expected_rsp_q [$];

  mhpq_req_if                    req_if ();
  mhpq_rsp_if #(.CNT_W(COUNT_W)) rsp_if ();

  min_heap_priority_queue_top #(
    .CAPACITY(HEAP_DEPTH)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL min_heap_priority_queue_top");
    $finish;
  end

  function automatic queue_result_t predict_queue_op(input logic op,
                                                     input logic signed [31:0] k);
    queue_result_t      r;
    int unsigned        pos;
    int unsigned        up;
    int unsigned        lc;
    int unsigned        rc;
    int unsigned        best;
    logic signed [31:0] t;
    bit                 settled;
    r.status  = ST_INSERTED;
    r.out_key = '0;
    settled   = 1'b0;
    if (op == FUNC_INSERT) begin
      if (model_size >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos             = model_size;
        model_keys[pos] = k;
        model_size++;
        while (pos > 0 && !settled) begin
          up = (pos - 1) / 2;
          if (model_keys[up] <= model_keys[pos]) begin
            settled = 1'b1;
          end else begin
            t               = model_keys[up];
            model_keys[up]  = model_keys[pos];
            model_keys[pos] = t;
            pos             = up;
          end
        end
      end
    end else if (model_size == 0) begin
      r.status  = ST_EMPTY;
      r.out_key = -32'sd1;
    end else begin
      r.status = ST_EXTRACTED;
      r.out_key = model_keys[0];
      model_size--;
      model_keys[0] = model_keys[model_size];
      pos = 0;
      while (!settled) begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        if (lc < model_size && model_keys[lc] < model_keys[best]) best = lc;
        if (rc < model_size && model_keys[rc] < model_keys[best]) best = rc;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          t                = model_keys[best];
          model_keys[best] = model_keys[pos];
          model_keys[pos]  = t;
          pos              = best;
        end
      end
    end
    r.count = COUNT_W'(model_size);
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit enable);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!enable || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] random_key();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3:    return int'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic op, input logic signed [31:0] k);
    int unsigned   gap;
    bit            taken;
    queue_result_t predicted;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= op;
    req_if.key   <= k;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (req_if.ready === 1'b1);
      @(posedge clk);
    end
    predicted      = predict_queue_op(op, k);
    expected_rsp_q = {expected_rsp_q, predicted};
  endtask

  // Response side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall = pick_gap(rx_idle_en);
      end
    end
  end

  initial begin
    queue_result_t seen;
    queue_result_t want;
    bit            fire;
    forever begin
      @(negedge clk);
      fire = (rsp_if.valid === 1'b1) && (rsp_if.ready === 1'b1);
      seen = {rsp_if.status, rsp_if.out_key, rsp_if.count};
      @(posedge clk);
      if (fire) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected beat: status %0d key %0d count %0d",
                   $time, seen.status, seen.out_key, seen.count);
          error_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (seen !== want) begin
            $display({"%0t: expected status %0d key %0d count %0d, ",
                      "got status %0d key %0d count %0d"},
                     $time, want.status, want.out_key, want.count,
                     seen.status, seen.out_key, seen.count);
            error_count++;
          end
        end
      end
    end
  end

  task automatic test_directed_edges();
    send_request(FUNC_EXTRACT, 32'sd0);
    send_request(FUNC_EXTRACT, -32'sd1);
    send_request(FUNC_INSERT, 32'sh7FFFFFFF);
    send_request(FUNC_INSERT, 32'sh80000000);
    send_request(FUNC_INSERT, 32'sd0);
    send_request(FUNC_INSERT, -32'sd1);
    repeat (3) send_request(FUNC_INSERT, 32'sd5);
    send_request(FUNC_INSERT, 32'sh80000000);
    send_request(FUNC_INSERT, 32'sh55555555);
    send_request(FUNC_INSERT, 32'shAAAAAAAA);
    repeat (10) send_request(FUNC_EXTRACT, $urandom);
    send_request(FUNC_EXTRACT, 32'sd0);
  endtask

  task automatic test_fill_and_drain();
    while (model_size < HEAP_DEPTH) send_request(FUNC_INSERT, random_key());
    repeat (3) send_request(FUNC_INSERT, random_key());
    send_request(FUNC_EXTRACT, random_key());
    send_request(FUNC_INSERT, random_key());
    send_request(FUNC_INSERT, random_key());
    while (model_size > 0) send_request(FUNC_EXTRACT, random_key());
    send_request(FUNC_EXTRACT, random_key());
  endtask

  task automatic test_random_mix();
    int unsigned phase;
    int unsigned insert_pct;
    for (int n = 0; n < 200; n++) begin
      phase      = n / 50;
      tx_idle_en = (phase % 2 == 0);
      rx_idle_en = (phase < 2);
      insert_pct = (phase % 2 == 0) ? 75 : 30;
      if ($urandom_range(0, 99) < insert_pct) begin
        send_request(FUNC_INSERT, random_key());
      end else begin
        send_request(FUNC_EXTRACT, random_key());
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 150;
    repeat (20) send_request(FUNC_INSERT, random_key());
    repeat (22) send_request(FUNC_EXTRACT, random_key());
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.func  <= FUNC_INSERT;
    req_if.key   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_fill_and_drain();
    test_random_mix();
    test_backpressure();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS min_heap_priority_queue_top");
    end else begin
      $display("FAIL min_heap_priority_queue_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_if.sv
rtl/mhpq_cell.sv
rtl/min_heap_priority_queue_top.sv
test/tb_min_heap_priority_queue_top.sv
